// ===== rtl/core/bpfa_pkg.sv =====
// Shared types, codes and constants of the bitmap page frame allocator.
package bpfa_pkg;

   // Frame numbers and region bounds derived from 32-bit byte addresses.
   localparam int CMP_W = 22;
   localparam int COUNT_W = 17;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   localparam int FRAME_COUNT_DEFAULT = 65536;
   localparam int LOW_RESERVED_DEFAULT = 256;

   localparam logic [2:0] ACT_RELEASE = 3'd0;
   localparam logic [2:0] ACT_RESERVE = 3'd1;
   localparam logic [2:0] ACT_CLOSE   = 3'd2;
   localparam logic [2:0] ACT_ALLOC   = 3'd3;
   localparam logic [2:0] ACT_FREE    = 3'd4;

   localparam logic [3:0] ST_OK           = 4'd0;
   localparam logic [3:0] ST_NOT_READY    = 4'd1;
   localparam logic [3:0] ST_UNALIGNED    = 4'd2;
   localparam logic [3:0] ST_OUT_OF_RANGE = 4'd3;
   localparam logic [3:0] ST_LOW_RESERVED = 4'd4;
   localparam logic [3:0] ST_DOUBLE_FREE  = 4'd5;
   localparam logic [3:0] ST_OUT_OF_MEM   = 4'd6;
   localparam logic [3:0] ST_NO_MEMORY    = 4'd7;
   localparam logic [3:0] ST_SETUP_CLOSED = 4'd8;

   typedef struct packed {
      logic [7:0] mask;
      logic [3:0] count;
      logic [2:0] first;
      logic [2:0] low_bit;
   } unit_result_type;

endpackage

// ===== rtl/core/bpfa_byte_unit.sv =====
// Shared per-byte unit: selects the frames of one bitmap byte that an action changes.
module bpfa_byte_unit (
   input  logic [2:0]                    mode,
   input  logic [7:0]                    data,
   input  logic [bpfa_pkg::CMP_W-1:0]    base,
   input  logic [bpfa_pkg::CMP_W-1:0]    lo,
   input  logic [bpfa_pkg::CMP_W-1:0]    hi,
   input  logic [bpfa_pkg::CMP_W-1:0]    low_res,
   output bpfa_pkg::unit_result_type     res
);

   always_comb begin
      logic [bpfa_pkg::CMP_W-1:0] f;
      logic                       in_range;
      res = '0;
      for (int k = 0; k < 8; k++) begin
         f = base + bpfa_pkg::CMP_W'(k);
         in_range = (f >= lo) && (f < hi);
         if (mode == bpfa_pkg::ACT_RELEASE) begin
            res.mask[k] = in_range && (f >= low_res) && !data[k];
         end else if (mode == bpfa_pkg::ACT_RESERVE) begin
            res.mask[k] = in_range && data[k];
         end else begin
            res.mask[k] = 1'b0;
         end
         res.count = res.count + 4'(res.mask[k]);
      end
      for (int k = 7; k >= 0; k--) begin
         if (res.mask[k]) begin
            res.first = 3'(k);
         end
         if (data[k]) begin
            res.low_bit = 3'(k);
         end
      end
   end

endmodule

// ===== rtl/core/bitmap_page_frame_allocator.sv =====
// A transaction passes a setup step and a finish step that registers the result; free, region
// actions and allocate add a read step and a modify step for each bitmap byte visited.
// One transaction at a time; the next request is taken at the earliest on the edge that
// accepts the result.
// After reset a clearing pass writes (FRAME_COUNT+7)/8 bitmap bytes, one per cycle, before the
// first request transaction is taken.
module bitmap_page_frame_allocator #(
   parameter int FRAME_COUNT = bpfa_pkg::FRAME_COUNT_DEFAULT,
   parameter int LOW_RESERVED_FRAMES = bpfa_pkg::LOW_RESERVED_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_action,
   input  logic [31:0] req_address,
   input  logic [31:0] req_length,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_status,
   output logic [27:0] rsp_frame_address,
   output logic [16:0] rsp_total_frames,
   output logic [16:0] rsp_free_frames,
   output logic [16:0] rsp_used_frames
);

   localparam int CW = bpfa_pkg::CMP_W;
   localparam int MAP_BYTES = (FRAME_COUNT + 7) / 8;
   localparam int AW = $clog2(MAP_BYTES);
   localparam int BW = $clog2(MAP_BYTES + 1);
   localparam int HMAX = (FRAME_COUNT > LOW_RESERVED_FRAMES) ? FRAME_COUNT : LOW_RESERVED_FRAMES;
   localparam int HW = $clog2(HMAX + 1);
   localparam int FW = $clog2(FRAME_COUNT + 1);
   localparam logic [CW-1:0] FC_C = CW'(FRAME_COUNT);
   localparam logic [CW-1:0] LOW_C = CW'(LOW_RESERVED_FRAMES);
   localparam logic [CW-1:0] MB_C = CW'(MAP_BYTES);

   typedef enum logic [5:0] {
      S_CLR   = 6'b000001,
      S_IDLE  = 6'b000010,
      S_SETUP = 6'b000100,
      S_RD    = 6'b001000,
      S_MOD   = 6'b010000,
      S_FIN   = 6'b100000
   } state_type;

   state_type   state_ff, state_in;
   logic [2:0]  act_ff, act_in;
   logic [31:0] addr_ff, addr_in;
   logic [31:0] len_ff, len_in;
   logic [CW-1:0] sf_ff, sf_in;
   logic [CW-1:0] lim_ff, lim_in;
   logic [BW-1:0] cur_ff, cur_in;
   logic [3:0]  status_ff, status_in;
   logic [27:0] fa_ff, fa_in;
   logic [16:0] total_ff, total_in;
   logic [FW-1:0] free_ff, free_in;
   logic [HW-1:0] hint_ff, hint_in;
   logic        ready_ff, ready_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [3:0]  rsp_status_ff, rsp_status_in;
   logic [27:0] rsp_fa_ff, rsp_fa_in;
   logic [16:0] rsp_total_ff, rsp_total_in;
   logic [16:0] rsp_free_ff, rsp_free_in;
   logic [16:0] rsp_used_ff, rsp_used_in;

   logic [7:0]  mem [MAP_BYTES];
   logic [7:0]  rd_q;
   logic        mem_we;
   logic [7:0]  mem_wd;
   logic [AW-1:0] mem_a;

   logic [CW-1:0] base_frame;
   bpfa_pkg::unit_result_type unit_res;
   logic        accept;

   assign base_frame = CW'(cur_ff) << 3;
   assign mem_a = AW'(cur_ff);
   assign req_stall = !((state_ff == S_IDLE) && (!rsp_valid_ff || !rsp_stall));
   assign accept = req_valid && !req_stall;

   bpfa_byte_unit u_unit (
      .mode    (act_ff),
      .data    (rd_q),
      .base    (base_frame),
      .lo      (sf_ff),
      .hi      (lim_ff),
      .low_res (LOW_C),
      .res     (unit_res)
   );

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_a] <= mem_wd;
      end
      rd_q <= mem[mem_a];
   end

   always_comb begin
      logic [32:0]   sum_start;
      logic [32:0]   sum_end;
      logic [33:0]   sum_res;
      logic [CW-1:0] ef;
      logic [CW-1:0] lim;
      logic [CW-1:0] f;
      logic [CW-1:0] nxt_x;
      logic [17:0]   tot_sum;
      logic [BW-1:0] nxt;
      logic [CW-1:0] tot_x;
      logic [CW-1:0] fr_x;
      state_in = state_ff;
      act_in = act_ff;
      addr_in = addr_ff;
      len_in = len_ff;
      sf_in = sf_ff;
      lim_in = lim_ff;
      cur_in = cur_ff;
      status_in = status_ff;
      fa_in = fa_ff;
      total_in = total_ff;
      free_in = free_ff;
      hint_in = hint_ff;
      ready_in = ready_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_fa_in = rsp_fa_ff;
      rsp_total_in = rsp_total_ff;
      rsp_free_in = rsp_free_ff;
      rsp_used_in = rsp_used_ff;
      mem_we = 1'b0;
      mem_wd = '0;
      sum_start = {1'b0, addr_ff} + 33'd4095;
      sum_end = {1'b0, addr_ff} + {1'b0, len_ff};
      sum_res = {2'b0, addr_ff} + {2'b0, len_ff} + 34'd4095;
      ef = '0;
      lim = '0;
      f = base_frame | CW'(rd_q == 8'd0 ? 3'd0 : unit_res.low_bit);
      nxt = cur_ff + 1'b1;
      nxt_x = CW'(nxt);
      tot_sum = {1'b0, total_ff} + 18'(unit_res.count);
      tot_x = CW'(total_ff);
      fr_x = CW'(free_ff);

      unique case (state_ff)
         S_CLR: begin
            mem_we = 1'b1;
            cur_in = nxt;
            if (CW'(cur_ff) == MB_C - 1'b1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               act_in = req_action;
               addr_in = req_address;
               len_in = req_length;
               state_in = S_SETUP;
            end
         end
         S_SETUP: begin
            status_in = bpfa_pkg::ST_OK;
            fa_in = '0;
            state_in = S_FIN;
            unique case (act_ff)
               bpfa_pkg::ACT_RELEASE, bpfa_pkg::ACT_RESERVE: begin
                  if (act_ff == bpfa_pkg::ACT_RELEASE) begin
                     sf_in = CW'(sum_start[32:12]);
                     ef = CW'(sum_end[32:12]);
                  end else begin
                     sf_in = CW'(addr_ff[31:12]);
                     ef = sum_res[33:12];
                  end
                  lim = (ef < FC_C) ? ef : FC_C;
                  lim_in = lim;
                  if (ready_ff) begin
                     status_in = bpfa_pkg::ST_SETUP_CLOSED;
                  end else if (sf_in < lim) begin
                     cur_in = BW'(sf_in >> 3);
                     state_in = S_RD;
                  end
               end
               bpfa_pkg::ACT_CLOSE: begin
                  if (ready_ff) begin
                     status_in = bpfa_pkg::ST_SETUP_CLOSED;
                  end else if (total_ff == '0) begin
                     status_in = bpfa_pkg::ST_NO_MEMORY;
                  end else begin
                     ready_in = 1'b1;
                  end
               end
               bpfa_pkg::ACT_ALLOC: begin
                  if (!ready_ff) begin
                     status_in = bpfa_pkg::ST_NOT_READY;
                  end else if ((CW'(hint_ff) >> 3) >= MB_C) begin
                     status_in = bpfa_pkg::ST_OUT_OF_MEM;
                  end else begin
                     cur_in = BW'(CW'(hint_ff) >> 3);
                     state_in = S_RD;
                  end
               end
               bpfa_pkg::ACT_FREE: begin
                  sf_in = CW'(addr_ff[31:12]);
                  if (!ready_ff) begin
                     status_in = bpfa_pkg::ST_NOT_READY;
                  end else if (addr_ff[11:0] != 12'd0) begin
                     status_in = bpfa_pkg::ST_UNALIGNED;
                  end else if (sf_in >= FC_C) begin
                     status_in = bpfa_pkg::ST_OUT_OF_RANGE;
                  end else if (sf_in < LOW_C) begin
                     status_in = bpfa_pkg::ST_LOW_RESERVED;
                  end else begin
                     cur_in = BW'(sf_in >> 3);
                     state_in = S_RD;
                  end
               end
               default: begin
                  status_in = bpfa_pkg::ST_OK;
               end
            endcase
         end
         S_RD: begin
            state_in = S_MOD;
         end
         S_MOD: begin
            state_in = S_FIN;
            unique case (act_ff)
               bpfa_pkg::ACT_RELEASE, bpfa_pkg::ACT_RESERVE: begin
                  mem_we = 1'b1;
                  if (act_ff == bpfa_pkg::ACT_RELEASE) begin
                     mem_wd = rd_q | unit_res.mask;
                     free_in = free_ff + FW'(unit_res.count);
                     total_in = (tot_sum > 18'(bpfa_pkg::COUNT_MAX)) ?
                                bpfa_pkg::COUNT_MAX : tot_sum[16:0];
                     if ((unit_res.mask != 8'd0) &&
                         ((base_frame | CW'(unit_res.first)) < CW'(hint_ff))) begin
                        hint_in = HW'(base_frame | CW'(unit_res.first));
                     end
                  end else begin
                     mem_wd = rd_q & ~unit_res.mask;
                     free_in = (free_ff >= FW'(unit_res.count)) ?
                               free_ff - FW'(unit_res.count) : '0;
                  end
                  if ((nxt_x << 3) < lim_ff) begin
                     cur_in = nxt;
                     state_in = S_RD;
                  end
               end
               bpfa_pkg::ACT_ALLOC: begin
                  if ((rd_q != 8'd0) && (f >= LOW_C) && (f < FC_C)) begin
                     mem_we = 1'b1;
                     mem_wd = rd_q & ~(8'd1 << unit_res.low_bit);
                     if (free_ff != '0) begin
                        free_in = free_ff - 1'b1;
                     end
                     hint_in = HW'(f + 1'b1);
                     fa_in = 28'({f, 12'd0});
                  end else if (nxt_x >= MB_C) begin
                     status_in = bpfa_pkg::ST_OUT_OF_MEM;
                  end else begin
                     cur_in = nxt;
                     state_in = S_RD;
                  end
               end
               bpfa_pkg::ACT_FREE: begin
                  if (rd_q[sf_ff[2:0]]) begin
                     status_in = bpfa_pkg::ST_DOUBLE_FREE;
                  end else begin
                     mem_we = 1'b1;
                     mem_wd = rd_q | (8'd1 << sf_ff[2:0]);
                     free_in = free_ff + 1'b1;
                     if (sf_ff < CW'(hint_ff)) begin
                        hint_in = HW'(sf_ff);
                     end
                  end
               end
               default: begin
                  status_in = status_ff;
               end
            endcase
         end
         S_FIN: begin
            rsp_valid_in = 1'b1;
            rsp_status_in = status_ff;
            rsp_fa_in = fa_ff;
            rsp_total_in = total_ff;
            rsp_free_in = 17'(free_ff);
            rsp_used_in = (tot_x > fr_x) ? 17'(tot_x - fr_x) : 17'd0;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         cur_ff <= '0;
         total_ff <= '0;
         free_ff <= '0;
         hint_ff <= HW'(LOW_RESERVED_FRAMES);
         ready_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cur_ff <= cur_in;
         total_ff <= total_in;
         free_ff <= free_in;
         hint_ff <= hint_in;
         ready_ff <= ready_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      act_ff <= act_in;
      addr_ff <= addr_in;
      len_ff <= len_in;
      sf_ff <= sf_in;
      lim_ff <= lim_in;
      status_ff <= status_in;
      fa_ff <= fa_in;
      rsp_status_ff <= rsp_status_in;
      rsp_fa_ff <= rsp_fa_in;
      rsp_total_ff <= rsp_total_in;
      rsp_free_ff <= rsp_free_in;
      rsp_used_ff <= rsp_used_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_frame_address = rsp_fa_ff;
   assign rsp_total_frames = rsp_total_ff;
   assign rsp_free_frames = rsp_free_ff;
   assign rsp_used_frames = rsp_used_ff;

`ifndef SYNTHESIS
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> req_stall)
      else $error("request accepted while a transaction is in progress");
   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> ($past(state_ff) == S_FIN))
      else $error("response raised outside the finish step");
   a_free_bounded: assert property (@(posedge clock) disable iff (reset)
      CW'(free_ff) <= FC_C)
      else $error("free count exceeds the frame count");
   a_addr_only_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_frame_address != 28'd0)) |-> (rsp_status == bpfa_pkg::ST_OK))
      else $error("frame address returned with a failing status");
`endif

endmodule
